// ===== rtl/core/bhpq_pkg.sv =====
package bhpq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic ORDER_MAX = 1'b0;
  localparam logic ORDER_MIN = 1'b1;

endpackage

// ===== rtl/core/bhpq_in_if.sv =====
interface bhpq_in_if import bhpq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

// ===== rtl/core/bhpq_out_if.sv =====
interface bhpq_out_if import bhpq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [VALUE_W-1:0] popped_value;
  logic [COUNT_W-1:0] entries_after;

  modport source (output valid, output accepted, output popped_value, output entries_after,
                  input ready);
  modport sink (input valid, input accepted, input popped_value, input entries_after,
                output ready);
endinterface

// ===== rtl/core/binary_heap_priority_queue.sv =====
// Binary heap priority queue, one item at a time; a result waits for ready, and the next item
// is taken only once the result is taken. Push: read the parent, then compare and write, for each
// tree level from the new slot up to the root. Pop: read the root and the last entry, then for each
// level the entry sinks, read the children, compare and write; a full push or empty pop is refused.
// One sequencer reuses the compare logic and the heap RAM port pair at every level.
// Reset (rst, synchronous): heap empty, max order; RAM contents are not cleared.
module binary_heap_priority_queue import bhpq_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  bhpq_in_if.sink    in_ch,
  bhpq_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_POP, S_DN_RD, S_DN_CMP, S_OUT
  } state_t;

  typedef logic [VALUE_BITS-1:0] val_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic            order;
  logic [AW-1:0]   pos;
  val_t            cur;
  logic            res_accepted;
  val_t            res_popped;

  val_t            mem [DEPTH];
  val_t            rdata0;
  val_t            rdata1;
  logic [AW-1:0]   raddr0;
  logic [AW-1:0]   raddr1;
  logic            we;
  logic [AW-1:0]   waddr;
  val_t            wdata;

  logic [AW-1:0]   parent;
  logic [LW-1:0]   l_idx;
  logic [LW-1:0]   r_idx;
  logic            l_ok;
  logic            r_ok;
  logic            take_l;
  val_t            child_val;
  logic [AW-1:0]   child_pos;
  logic            up_swap;
  logic            dn_swap;
  logic [CW-1:0]   last;

  function automatic logic better(input logic ord, input val_t a, input val_t b);
    better = (ord == ORDER_MIN) ? (a < b) : (a > b);
  endfunction

  assign parent    = (pos - AW'(1)) >> 1;
  assign l_idx     = LW'({pos, 1'b1});
  assign r_idx     = l_idx + LW'(1);
  assign l_ok      = l_idx < LW'(count);
  assign r_ok      = r_idx < LW'(count);
  assign take_l    = !r_ok || better(order, rdata0, rdata1);
  assign child_val = take_l ? rdata0 : rdata1;
  assign child_pos = take_l ? l_idx[AW-1:0] : r_idx[AW-1:0];
  assign up_swap   = better(order, cur, rdata0);
  assign dn_swap   = better(order, child_val, cur);
  assign last      = count - CW'(1);

  assign in_ch.ready          = (state == S_IDLE);
  assign out_ch.valid         = (state == S_OUT);
  assign out_ch.accepted      = res_accepted;
  assign out_ch.popped_value  = VALUE_W'(res_popped);
  assign out_ch.entries_after = COUNT_W'(count);

  always_comb begin
    raddr0 = '0;
    raddr1 = '0;
    we     = 1'b0;
    waddr  = pos;
    wdata  = cur;
    case (state)
      S_IDLE: begin
        raddr0 = '0;
        raddr1 = last[AW-1:0];
      end
      S_UP_RD: begin
        raddr0 = parent;
        we     = (pos == '0);
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = up_swap ? rdata0 : cur;
      end
      S_DN_RD: begin
        raddr0 = l_idx[AW-1:0];
        raddr1 = r_idx[AW-1:0];
        we     = !l_ok;
      end
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = dn_swap ? child_val : cur;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      order        <= ORDER_MAX;
      res_accepted <= 1'b0;
    end else begin
      if (cfg_we) begin
        order <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            res_popped <= '0;
            if (in_ch.action == ACT_PUSH) begin
              if (count == CW'(DEPTH)) begin
                res_accepted <= 1'b0;
                state        <= S_OUT;
              end else begin
                res_accepted <= 1'b1;
                cur          <= VALUE_BITS'(in_ch.value);
                pos          <= count[AW-1:0];
                count        <= count + CW'(1);
                state        <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                res_accepted <= 1'b0;
                state        <= S_OUT;
              end else begin
                res_accepted <= 1'b1;
                count        <= last;
                state        <= S_POP;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_OUT : S_UP_CMP;
        end
        S_UP_CMP: begin
          pos   <= parent;
          cur   <= up_swap ? cur : rdata0;
          state <= S_UP_RD;
        end
        S_POP: begin
          res_popped <= rdata0;
          cur        <= rdata1;
          pos        <= '0;
          state      <= (count == '0) ? S_OUT : S_DN_RD;
        end
        S_DN_RD: begin
          state <= l_ok ? S_DN_CMP : S_OUT;
        end
        S_DN_CMP: begin
          if (dn_swap) begin
            pos   <= child_pos;
            state <= S_DN_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_binary_heap_priority_queue.sv =====
`timescale 1ns / 100ps

module tb_binary_heap_priority_queue;
  import bhpq_pkg::*;

  localparam int HEAP_DEPTH  = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic               accepted;
    logic [VALUE_W-1:0] popped;
    logic [COUNT_W-1:0] entries;
  } heap_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  bhpq_in_if  in_ch();
  bhpq_out_if out_ch();

  binary_heap_priority_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the heap contents and the order register
  logic [VALUE_W-1:0] heap_mirror [HEAP_DEPTH];
  int                 heap_size;
  logic               order_mirror;

  heap_result_t expected_results [$];
  heap_result_t want;
  int           mismatch_count;
  int           quiet_cycles;
  bit           gaps_on;
  int           stall_len;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic outranks(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
    return (order_mirror == ORDER_MIN) ? (a < b) : (a > b);
  endfunction

  function automatic void swap_slots(int i, int j);
    logic [VALUE_W-1:0] t;
    t              = heap_mirror[i];
    heap_mirror[i] = heap_mirror[j];
    heap_mirror[j] = t;
  endfunction

  function automatic heap_result_t predict_heap_item(logic act, logic [VALUE_W-1:0] val);
    heap_result_t r;
    int pos, up, l, rt, pick;
    bit done;
    r = '0;
    if (act == ACT_PUSH) begin
      if (heap_size < HEAP_DEPTH) begin
        heap_mirror[heap_size] = val;
        pos = heap_size;
        heap_size++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (outranks(heap_mirror[pos], heap_mirror[up])) swap_slots(pos, up);
          pos = up;
        end
        r.accepted = 1'b1;
      end
    end else if (heap_size != 0) begin
      r.popped = heap_mirror[0];
      heap_size--;
      if (heap_size != 0) begin
        heap_mirror[0] = heap_mirror[heap_size];
        pos  = 0;
        done = 0;
        while (!done) begin
          l  = 2 * pos + 1;
          rt = l + 1;
          if (l >= heap_size) begin
            done = 1;
          end else begin
            // ties go to the right child
            if (rt < heap_size) pick = outranks(heap_mirror[l], heap_mirror[rt]) ? l : rt;
            else pick = l;
            if (!outranks(heap_mirror[pick], heap_mirror[pos])) begin
              done = 1;
            end else begin
              swap_slots(pos, pick);
              pos = pick;
            end
          end
        end
      end
      r.accepted = 1'b1;
    end
    r.entries = heap_size[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] exp_v);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch %s: got %h expected %h", what, got, exp_v);
  endtask

  // One item on the input channel; valid stays high on return
  task automatic send_item(logic act, logic [VALUE_W-1:0] val);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_results.push_back(predict_heap_item(act, val));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(logic ord);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ord;
    @(posedge clk);
    cfg_we       <= 1'b0;
    order_mirror = ord;
  endtask

  task automatic test_directed();
    // max order: empty pop, extremes, duplicates, drain past empty
    send_item(ACT_POP, 32'h1234_5678);
    send_item(ACT_PUSH, 32'h0);
    send_item(ACT_PUSH, 32'hFFFF_FFFF);
    send_item(ACT_PUSH, 32'h7);
    send_item(ACT_PUSH, 32'h7);
    send_item(ACT_PUSH, 32'h8000_0000);
    send_item(ACT_PUSH, 32'h1);
    repeat (7) send_item(ACT_POP, 32'hFFFF_FFFF);
    set_order(ORDER_MIN);
    send_item(ACT_PUSH, 32'h5);
    send_item(ACT_PUSH, 32'h5);
    send_item(ACT_PUSH, 32'h0);
    send_item(ACT_PUSH, 32'hFFFF_FFFF);
    send_item(ACT_PUSH, 32'h3);
    repeat (5) send_item(ACT_POP, 32'h0);
  endtask

  task automatic test_full_heap(logic ord);
    set_order(ord);
    repeat (HEAP_DEPTH + 1) send_item(ACT_PUSH, pick_value());
    repeat (HEAP_DEPTH + 1) send_item(ACT_POP, $urandom);
  endtask

  task automatic test_random(logic ord, int n);
    int push_pct;
    set_order(ord);
    push_pct = 60;
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) push_pct = $urandom_range(0, 2) == 0 ? 25 : ($urandom_range(0, 1) ? 55 : 85);
      if ($urandom_range(0, 99) < push_pct) send_item(ACT_PUSH, pick_value());
      else send_item(ACT_POP, $urandom);
    end
  endtask

  task automatic test_receiver_hold();
    drain();
    stall_len = LONG_HOLD;
    repeat (30) send_item($urandom_range(0, 2) == 0 ? ACT_POP : ACT_PUSH, pick_value());
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      repeat (15) send_item($urandom_range(0, 1) ? ACT_POP : ACT_PUSH, pick_value());
      drain();
    end
  endtask

  task automatic test_quiet_tail();
    drain();
    gaps_on = 0;
    test_random(ORDER_MIN, 150);
  endtask

  // Receiver: random stalls plus an occasional long hold
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
        stall_len = 0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", out_ch.popped_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.accepted !== want.accepted)
          report_mismatch("accepted", VALUE_W'(out_ch.accepted), VALUE_W'(want.accepted));
        if (out_ch.popped_value !== want.popped)
          report_mismatch("popped_value", out_ch.popped_value, want.popped);
        if (out_ch.entries_after !== want.entries)
          report_mismatch("entries_after", VALUE_W'(out_ch.entries_after),
                          VALUE_W'(want.entries));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_PUSH;
    in_ch.value    <= '0;
    heap_size      = 0;
    order_mirror   = ORDER_MAX;
    mismatch_count = 0;
    gaps_on        = 1;
    stall_len      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_heap(ORDER_MAX);
    test_full_heap(ORDER_MIN);
    test_random(ORDER_MAX, 250);
    test_receiver_hold();
    test_random(ORDER_MIN, 250);
    test_sender_pause();
    test_random(ORDER_MAX, 120);
    test_quiet_tail();

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bhpq_pkg.sv
rtl/core/bhpq_in_if.sv
rtl/core/bhpq_out_if.sv
rtl/core/binary_heap_priority_queue.sv
dv/tb_binary_heap_priority_queue.sv
